[sv/xme_pkg.sv]
// ----------------------------------------------------------------------------
// xme_pkg
// Types and encoding constants shared by the x86-64 MOV encoder modules.
// ----------------------------------------------------------------------------
package xme_pkg;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned IdxW     = 4;

  typedef enum logic [1:0] {
    ACT_REG   = 2'd0,
    ACT_STORE = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_IMM   = 2'd3
  } act_e;

  localparam logic [7:0] REX_W        = 8'h48;
  localparam logic [7:0] OPC_MOV_RM   = 8'h89;
  localparam logic [7:0] OPC_MOV_MR   = 8'h8b;
  localparam logic [7:0] OPC_MOV_IMM  = 8'hc7;
  localparam logic [7:0] OPC_MOV_RI   = 8'hb8;
  localparam logic [7:0] SIB_RSP      = 8'h24;
  localparam logic [7:0] MODRM_RSP_D0 = 8'h04;
  localparam logic [7:0] MODRM_RSP_D8 = 8'h44;
  localparam logic [7:0] MODRM_RSP_D32 = 8'h84;
  localparam logic [7:0] MODRM_RBP_D8 = 8'h45;
  localparam logic [7:0] MODRM_RBP_D32 = 8'h85;
  localparam logic [7:0] MODRM_REG    = 8'hc0;
  localparam logic [63:0] SEXT32_MASK = 64'hffffffff80000000;

  // One encoded instruction: bytes in emission order, index of the final byte.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
  } instr_t;

endpackage

[sv/xme_if.sv]
// ----------------------------------------------------------------------------
// xme_req_if / xme_byte_if
// Valid/ready channels: move requests in, machine code bytes out.
// ----------------------------------------------------------------------------
interface xme_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  dst_reg;
  logic [3:0]  src_reg;
  logic [12:0] slot;
  logic [63:0] imm;

  modport source (output valid, action, dst_reg, src_reg, slot, imm, input ready);
  modport sink   (input valid, action, dst_reg, src_reg, slot, imm, output ready);
endinterface

interface xme_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last;

  modport source (output valid, code_byte, last, input ready);
  modport sink   (input valid, code_byte, last, output ready);
endinterface

[sv/xme_front.sv]
// ----------------------------------------------------------------------------
// xme_front
// Accepts a move request, picks the shortest encoding form it supports and builds its byte image.
// ----------------------------------------------------------------------------
module xme_front import xme_pkg::*; (
  xme_req_if.sink req_i,
  input  logic    q_ready_i,
  output logic    q_push_o,
  output instr_t  q_data_o
);

  logic        dhi, shi;
  logic [2:0]  dlo, slo;
  logic [16:0] ld_off;
  logic [31:0] st_disp;
  logic [31:0] ld_disp;
  logic        fits_u32, fits_i32;
  logic [63:0] imm_top;
  act_e        act;

  assign act      = act_e'(req_i.action);
  assign dhi      = req_i.dst_reg[3];
  assign dlo      = req_i.dst_reg[2:0];
  assign shi      = req_i.src_reg[3];
  assign slo      = req_i.src_reg[2:0];
  assign st_disp  = {16'b0, req_i.slot, 3'b000};
  assign ld_off   = 17'd16 + {1'b0, req_i.slot, 3'b000};
  assign ld_disp  = {15'b0, ld_off};
  assign imm_top  = req_i.imm & SEXT32_MASK;
  assign fits_u32 = (req_i.imm[63:32] == 32'b0);
  assign fits_i32 = (imm_top == 64'b0) || (imm_top == SEXT32_MASK);

  assign req_i.ready = q_ready_i;
  assign q_push_o    = req_i.valid && q_ready_i;

  always_comb begin
    q_data_o = '0;
    case (act)
      ACT_REG: begin
        q_data_o.bytes[0] = REX_W | {5'b0, shi, 1'b0, dhi};
        q_data_o.bytes[1] = OPC_MOV_RM;
        q_data_o.bytes[2] = MODRM_REG | {2'b0, slo, dlo};
        q_data_o.last_idx = IdxW'(2);
      end
      ACT_STORE: begin
        q_data_o.bytes[0] = REX_W | {5'b0, shi, 2'b0};
        q_data_o.bytes[1] = OPC_MOV_RM;
        q_data_o.bytes[3] = SIB_RSP;
        if (req_i.slot == 13'd0) begin
          q_data_o.bytes[2] = MODRM_RSP_D0 | {2'b0, slo, 3'b0};
          q_data_o.last_idx = IdxW'(3);
        end else if (req_i.slot < 13'd16) begin
          q_data_o.bytes[2] = MODRM_RSP_D8 | {2'b0, slo, 3'b0};
          q_data_o.bytes[4] = st_disp[7:0];
          q_data_o.last_idx = IdxW'(4);
        end else begin
          q_data_o.bytes[2] = MODRM_RSP_D32 | {2'b0, slo, 3'b0};
          for (int i = 0; i < 4; i++) q_data_o.bytes[4+i] = st_disp[8*i +: 8];
          q_data_o.last_idx = IdxW'(7);
        end
      end
      ACT_LOAD: begin
        q_data_o.bytes[0] = REX_W | {5'b0, dhi, 2'b0};
        q_data_o.bytes[1] = OPC_MOV_MR;
        if (ld_off < 17'd128) begin
          q_data_o.bytes[2] = MODRM_RBP_D8 | {2'b0, dlo, 3'b0};
          q_data_o.bytes[3] = ld_disp[7:0];
          q_data_o.last_idx = IdxW'(3);
        end else begin
          q_data_o.bytes[2] = MODRM_RBP_D32 | {2'b0, dlo, 3'b0};
          for (int i = 0; i < 4; i++) q_data_o.bytes[3+i] = ld_disp[8*i +: 8];
          q_data_o.last_idx = IdxW'(6);
        end
      end
      ACT_IMM: begin
        if (!dhi && fits_u32) begin
          q_data_o.bytes[0] = OPC_MOV_RI | {5'b0, dlo};
          for (int i = 0; i < 4; i++) q_data_o.bytes[1+i] = req_i.imm[8*i +: 8];
          q_data_o.last_idx = IdxW'(4);
        end else if (fits_i32) begin
          q_data_o.bytes[0] = REX_W | {7'b0, dhi};
          q_data_o.bytes[1] = OPC_MOV_IMM;
          q_data_o.bytes[2] = MODRM_REG | {5'b0, dlo};
          for (int i = 0; i < 4; i++) q_data_o.bytes[3+i] = req_i.imm[8*i +: 8];
          q_data_o.last_idx = IdxW'(6);
        end else begin
          q_data_o.bytes[0] = REX_W | {7'b0, dhi};
          q_data_o.bytes[1] = OPC_MOV_RI | {5'b0, dlo};
          for (int i = 0; i < 8; i++) q_data_o.bytes[2+i] = req_i.imm[8*i +: 8];
          q_data_o.last_idx = IdxW'(9);
        end
      end
      default: q_data_o = '0;
    endcase
  end

endmodule

[sv/xme_queue.sv]
// ----------------------------------------------------------------------------
// xme_queue
// Short FIFO of encoded instructions between the front and the back.
// ----------------------------------------------------------------------------
module xme_queue import xme_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  instr_t push_data_i,
  output logic   push_ready_o,
  input  logic   pop_i,
  output logic   pop_valid_o,
  output instr_t pop_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  instr_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[sv/xme_back.sv]
// ----------------------------------------------------------------------------
// xme_back
// Holds one encoded instruction and sends it out one byte per beat.
// ----------------------------------------------------------------------------
module xme_back import xme_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  instr_t q_data_i,
  output logic   q_pop_o,
  xme_byte_if.source code_o
);

  instr_t          cur_q;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            is_last, fire;

  assign is_last        = (idx_q == cur_q.last_idx);
  assign fire           = busy_q && code_o.ready;
  assign code_o.valid   = busy_q;
  assign code_o.code_byte = cur_q.bytes[idx_q];
  assign code_o.last    = is_last;

  // reload on the last beat so the next instruction follows without a gap
  assign q_pop_o = !busy_q || (fire && is_last);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (q_pop_o) begin
      busy_d = q_valid_i;
      idx_d  = '0;
    end else if (fire) begin
      idx_d  = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_valid_i) cur_q <= q_data_i;
  end

endmodule

[sv/x86_64_mov_encoder.sv]
// ----------------------------------------------------------------------------
// x86_64_mov_encoder
// Encodes one MOV request into its x86-64 machine code byte stream.
// ----------------------------------------------------------------------------
// req_i carries a request (action, dst_reg, src_reg, slot, imm); code_o
// delivers the instruction one byte per beat, with last set on the final
// byte. Instructions are 3 to 10 bytes long.
// The front end encodes a request combinationally and writes it into a
// QDepth-entry queue, so req_i.ready is high whenever the queue has room.
// The back end shifts bytes out of a holding register: the first byte of a
// request appears on code_o once it has passed through the queue and been
// loaded into the holding register. The output port moves one byte per cycle
// while code_o is ready; the next instruction starts on the cycle after the
// previous last byte if one is waiting in the queue.
// A stall on code_o holds the current byte; requests keep being taken until
// the queue is full. Reset empties the queue and the holding register.
// ----------------------------------------------------------------------------
module x86_64_mov_encoder import xme_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  xme_req_if.sink    req_i,
  xme_byte_if.source code_o
);

  logic   push, push_ready, pop, pop_valid;
  instr_t push_data, pop_data;

  xme_front u_front (
    .req_i     (req_i),
    .q_ready_i (push_ready),
    .q_push_o  (push),
    .q_data_o  (push_data)
  );

  xme_queue #(.Depth(QDepth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  xme_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .code_o    (code_o)
  );

endmodule

[sv/xme_checker.sv]
// ----------------------------------------------------------------------------
// xme_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module xme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  logic       start_q;
  logic [3:0] cnt_q;
  logic       fire;

  assign fire = out_valid_i && out_ready_i;

  // tracks position within the current instruction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      cnt_q   <= '0;
    end else if (fire) begin
      start_q <= out_last_i;
      cnt_q   <= out_last_i ? 4'd0 : cnt_q + 4'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled beat changed");

  // first byte is a REX.W prefix or the short B8+r opcode
  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && start_q |->
      (out_byte_i[7:3] == 5'b01001 && !out_byte_i[1]) || (out_byte_i[7:3] == 5'b10111))
    else $error("bad first byte of instruction");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && cnt_q == 4'd9 |-> out_last_i)
    else $error("instruction longer than ten bytes");

  a_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && cnt_q < 4'd2 |-> !out_last_i)
    else $error("instruction shorter than three bytes");

endmodule

bind x86_64_mov_encoder xme_checker u_xme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (code_o.valid),
  .out_ready_i (code_o.ready),
  .out_byte_i  (code_o.code_byte),
  .out_last_i  (code_o.last)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the x86-64 MOV encoder byte for byte against an in-bench encoder.
// Requests are queued by a stimulus process, a directed set first and then
// random requests in phases with varying idle and stall rates. Every accepted
// request is encoded here and its bytes are matched in order against the
// beats that leave code_o.
// ----------------------------------------------------------------------------
module testbench;
  import xme_pkg::*;

  localparam int unsigned RandPerPhase = 50;
  localparam int unsigned LongHold     = 80;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned MaxReports   = 10;

  typedef struct {
    act_e        action;
    logic [3:0]  dst_reg;
    logic [3:0]  src_reg;
    logic [12:0] slot;
    logic [63:0] imm;
  } mov_req_t;

  typedef struct {
    logic [7:0] code_byte;
    logic       last;
  } code_beat_t;

  logic clk_i;
  logic rst_ni;

  xme_req_if  req_if ();
  xme_byte_if code_if ();

  x86_64_mov_encoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .code_o(code_if)
  );

  mov_req_t    mov_req_q[$];
  code_beat_t  code_exp_q[$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic        req_beat = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected machine code of one request, appended to code_exp_q.
  function automatic void encode_mov(input mov_req_t r);
    logic [7:0]  bytes[$];
    logic [63:0] le_val;
    logic [63:0] top;
    logic [31:0] disp;
    int          le_len;
    le_val = '0;
    le_len = 0;
    case (r.action)
      ACT_REG: begin
        bytes.push_back(REX_W | {5'd0, r.src_reg[3], 1'b0, r.dst_reg[3]});
        bytes.push_back(OPC_MOV_RM);
        bytes.push_back(MODRM_REG | {2'd0, r.src_reg[2:0], r.dst_reg[2:0]});
      end
      ACT_STORE: begin
        disp = {16'd0, r.slot, 3'd0};
        le_val = {32'd0, disp};
        bytes.push_back(REX_W | {5'd0, r.src_reg[3], 2'd0});
        bytes.push_back(OPC_MOV_RM);
        if (r.slot == 0) begin
          bytes.push_back(MODRM_RSP_D0 | {2'd0, r.src_reg[2:0], 3'd0});
          bytes.push_back(SIB_RSP);
        end else if (r.slot < 16) begin
          bytes.push_back(MODRM_RSP_D8 | {2'd0, r.src_reg[2:0], 3'd0});
          bytes.push_back(SIB_RSP);
          le_len = 1;
        end else begin
          bytes.push_back(MODRM_RSP_D32 | {2'd0, r.src_reg[2:0], 3'd0});
          bytes.push_back(SIB_RSP);
          le_len = 4;
        end
      end
      ACT_LOAD: begin
        // rbp frame: slots start above the saved rbp and return address
        disp = 32'd16 + {16'd0, r.slot, 3'd0};
        le_val = {32'd0, disp};
        bytes.push_back(REX_W | {5'd0, r.dst_reg[3], 2'd0});
        bytes.push_back(OPC_MOV_MR);
        if (disp < 128) begin
          bytes.push_back(MODRM_RBP_D8 | {2'd0, r.dst_reg[2:0], 3'd0});
          le_len = 1;
        end else begin
          bytes.push_back(MODRM_RBP_D32 | {2'd0, r.dst_reg[2:0], 3'd0});
          le_len = 4;
        end
      end
      ACT_IMM: begin
        le_val = r.imm;
        top = r.imm & SEXT32_MASK;
        if (!r.dst_reg[3] && r.imm[63:32] == 32'd0) begin
          bytes.push_back(OPC_MOV_RI | {5'd0, r.dst_reg[2:0]});
          le_len = 4;
        end else if (top == 64'd0 || top == SEXT32_MASK) begin
          bytes.push_back(REX_W | {7'd0, r.dst_reg[3]});
          bytes.push_back(OPC_MOV_IMM);
          bytes.push_back(MODRM_REG | {5'd0, r.dst_reg[2:0]});
          le_len = 4;
        end else begin
          bytes.push_back(REX_W | {7'd0, r.dst_reg[3]});
          bytes.push_back(OPC_MOV_RI | {5'd0, r.dst_reg[2:0]});
          le_len = 8;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < le_len; i++) bytes.push_back(le_val[8*i +: 8]);
    foreach (bytes[i]) code_exp_q.push_back('{bytes[i], i == bytes.size() - 1});
  endfunction

  task automatic add_req(input act_e a, input logic [3:0] d, input logic [3:0] s,
                         input logic [12:0] sl, input logic [63:0] im);
    mov_req_q.push_back('{a, d, s, sl, im});
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || code_exp_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : beat_monitor
    mov_req_t   got;
    code_beat_t want;
    if (!rst_ni) begin
      req_beat = 1'b0;
    end else begin
      req_beat = req_if.valid && req_if.ready;
      if (req_beat) begin
        got = '{act_e'(req_if.action), req_if.dst_reg, req_if.src_reg,
                req_if.slot, req_if.imm};
        encode_mov(got);
        n_taken++;
      end
      if (code_if.valid && code_if.ready) begin
        if (code_exp_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("unexpected beat: byte %02h last %0b", code_if.code_byte,
                     code_if.last);
        end else begin
          want = code_exp_q.pop_front();
          if (code_if.code_byte !== want.code_byte || code_if.last !== want.last) begin
            n_errors++;
            if (n_errors <= MaxReports)
              $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       want.code_byte, want.last, code_if.code_byte, code_if.last);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : req_driver
    mov_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_beat) begin
      if (mov_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = mov_req_q.pop_front();
        req_if.valid   <= 1'b1;
        req_if.action  <= nxt.action;
        req_if.dst_reg <= nxt.dst_reg;
        req_if.src_reg <= nxt.src_reg;
        req_if.slot    <= nxt.slot;
        req_if.imm     <= nxt.imm;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin : code_ready_driver
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      code_if.ready <= 1'b0;
    end else begin
      code_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    act_e        a;
    logic [12:0] sl;
    logic [63:0] im;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.action  = ACT_REG;
    req_if.dst_reg = '0;
    req_if.src_reg = '0;
    req_if.slot    = '0;
    req_if.imm     = '0;
    code_if.ready  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: register extremes, every slot form and every immediate form
    add_req(ACT_REG,   4'd0,  4'd0,  13'd8191, '1);
    add_req(ACT_REG,   4'd15, 4'd15, 13'd0,    '0);
    add_req(ACT_REG,   4'd7,  4'd8,  13'd5,    64'h1234);
    add_req(ACT_STORE, 4'd15, 4'd0,  13'd0,    '1);
    add_req(ACT_STORE, 4'd0,  4'd15, 13'd1,    '0);
    add_req(ACT_STORE, 4'd3,  4'd7,  13'd15,   '0);
    add_req(ACT_STORE, 4'd9,  4'd8,  13'd16,   '0);
    add_req(ACT_STORE, 4'd0,  4'd3,  13'd8191, '0);
    add_req(ACT_LOAD,  4'd0,  4'd15, 13'd0,    '1);
    add_req(ACT_LOAD,  4'd15, 4'd0,  13'd13,   '0);
    add_req(ACT_LOAD,  4'd9,  4'd0,  13'd14,   '0);
    add_req(ACT_LOAD,  4'd7,  4'd0,  13'd8191, '0);
    add_req(ACT_IMM,   4'd0,  4'd15, 13'd8191, 64'd0);
    add_req(ACT_IMM,   4'd7,  4'd0,  13'd0,    64'h0000_0000_ffff_ffff);
    add_req(ACT_IMM,   4'd8,  4'd0,  13'd0,    64'h0000_0000_7fff_ffff);
    // high register with an unsigned 32-bit value that does not sign-extend
    add_req(ACT_IMM,   4'd15, 4'd0,  13'd0,    64'h0000_0000_8000_0000);
    add_req(ACT_IMM,   4'd3,  4'd0,  13'd0,    64'hffff_ffff_8000_0000);
    add_req(ACT_IMM,   4'd0,  4'd0,  13'd0,    64'hffff_ffff_ffff_ffff);
    add_req(ACT_IMM,   4'd12, 4'd0,  13'd0,    64'd0);
    add_req(ACT_IMM,   4'd5,  4'd0,  13'd0,    64'h0000_0001_0000_0000);
    add_req(ACT_IMM,   4'd15, 4'd0,  13'd0,    64'h8000_0000_0000_0000);
    add_req(ACT_IMM,   4'd6,  4'd0,  13'd0,    64'hffff_fffe_ffff_ffff);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 72; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        a = act_e'(2'($urandom_range(3)));
        case ($urandom_range(5))
          0:       sl = 13'd0;
          1:       sl = 13'($urandom_range(1, 15));
          2:       sl = 13'($urandom_range(13, 14));
          3:       sl = 13'd8191;
          default: sl = 13'($urandom);
        endcase
        case ($urandom_range(5))
          0:       im = {32'd0, 32'($urandom)};
          1:       im = {32'hffff_ffff, 1'b1, 31'($urandom)};
          2:       im = {33'd0, 31'($urandom)};
          3:       im = {32'd0, 1'b1, 31'($urandom)};
          4:       im = $urandom_range(1) ? 64'd0 : '1;
          default: im = {32'($urandom), 32'($urandom)};
        endcase
        add_req(a, 4'($urandom), 4'($urandom), sl, im);
      end
      // long receiver hold-off while the sender keeps offering
      if (phase == 0) hold_asks++;
      wait_drained();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (n_errors == 0 && code_exp_q.size() == 0) begin
      $display("[x86_64_mov_encoder] OK");
    end else begin
      $display("[x86_64_mov_encoder] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[x86_64_mov_encoder] ERROR");
    $finish;
  end

endmodule

[files.f]
sv/xme_pkg.sv
sv/xme_if.sv
sv/xme_front.sv
sv/xme_queue.sv
sv/xme_back.sv
sv/x86_64_mov_encoder.sv
sv/xme_checker.sv
tb/sv/testbench.sv
